// ===== hdl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define STT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define STT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ===== hdl/stt_pkg.sv =====
package stt_pkg;

    localparam int unsigned SPAN_W  = 24;
    localparam int unsigned VALUE_W = 63;
    localparam int unsigned MAX_TOK = 3;

    localparam logic [5:0] K_PLUS    = 6'd0;
    localparam logic [5:0] K_MINUS   = 6'd1;
    localparam logic [5:0] K_STAR    = 6'd2;
    localparam logic [5:0] K_SLASH   = 6'd3;
    localparam logic [5:0] K_PERCENT = 6'd4;
    localparam logic [5:0] K_LPAREN  = 6'd5;
    localparam logic [5:0] K_RPAREN  = 6'd6;
    localparam logic [5:0] K_LBRACE  = 6'd7;
    localparam logic [5:0] K_RBRACE  = 6'd8;
    localparam logic [5:0] K_LBRACK  = 6'd9;
    localparam logic [5:0] K_RBRACK  = 6'd10;
    localparam logic [5:0] K_SEMI    = 6'd11;
    localparam logic [5:0] K_COLON   = 6'd12;
    localparam logic [5:0] K_COMMA   = 6'd13;
    localparam logic [5:0] K_DOT     = 6'd14;
    localparam logic [5:0] K_DEC     = 6'd15;
    localparam logic [5:0] K_SHL     = 6'd16;
    localparam logic [5:0] K_SHR     = 6'd17;
    localparam logic [5:0] K_LT      = 6'd18;
    localparam logic [5:0] K_LE      = 6'd19;
    localparam logic [5:0] K_GT      = 6'd20;
    localparam logic [5:0] K_GE      = 6'd21;
    localparam logic [5:0] K_EQ      = 6'd22;
    localparam logic [5:0] K_NE      = 6'd23;
    localparam logic [5:0] K_ASSIGN  = 6'd24;
    localparam logic [5:0] K_KW_BASE = 6'd25;
    localparam logic [5:0] K_IDENT   = 6'd40;
    localparam logic [5:0] K_STRING  = 6'd41;
    localparam logic [5:0] K_INT     = 6'd42;
    localparam logic [5:0] K_FLOAT   = 6'd43;
    localparam logic [5:0] K_END     = 6'd44;
    localparam logic [5:0] K_ERROR   = 6'd45;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_BAD_CHAR = 3'd1;
    localparam logic [2:0] E_BAD_ESC  = 3'd2;
    localparam logic [2:0] E_UNCLOSED = 3'd3;
    localparam logic [2:0] E_NUMBER   = 3'd4;
    localparam logic [2:0] E_OVERFLOW = 3'd5;

    localparam logic [1:0] B_DEC = 2'd0;
    localparam logic [1:0] B_HEX = 2'd1;
    localparam logic [1:0] B_BIN = 2'd2;

    localparam int unsigned NUM_KW = 15;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'("if"), 48'("else"), 48'("for"), 48'("in"), 48'("while"),
        48'("break"), 48'("return"), 48'("int"), 48'("bool"), 48'("string"),
        48'("and"), 48'("or"), 48'("not"), 48'("true"), 48'("false")
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd2, 3'd4, 3'd3, 3'd2, 3'd5, 3'd5, 3'd6, 3'd3, 3'd4, 3'd6,
        3'd3, 3'd2, 3'd3, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [5:0]         kind;
        logic [2:0]         err;
        logic [SPAN_W-1:0]  span_start;
        logic [SPAN_W-1:0]  span_end;
        logic [VALUE_W-1:0] value;
        logic [1:0]         base;
        logic               expo;
    } t_token;

    // tokens caused by one byte
    typedef struct packed {
        logic [1:0]               cnt;
        t_token [MAX_TOK-1:0]     tok;
    } t_group;

endpackage

// ===== hdl/stt_ifs.sv =====
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface stt_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [23:0] span_start;
    logic [23:0] span_end;
    logic [62:0] int_value;
    logic [1:0]  int_base;
    logic        has_exponent;
    logic        last_of_run;
    modport source (output valid, output token_kind, output error_code, output span_start,
                    output span_end, output int_value, output int_base,
                    output has_exponent, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input error_code, input span_start,
                  input span_end, input int_value, input int_base,
                  input has_exponent, input last_of_run, output ready);
endinterface

// ===== hdl/stt_front.sv =====
`include "assert_macros.svh"

module stt_front #(
    parameter int unsigned POSITION_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stt_byte_if.sink         i_src,
    input  logic             i_full,
    output logic             o_push,
    output stt_pkg::t_group  o_grp
);

    localparam int unsigned PB = POSITION_BITS;

    typedef enum logic [18:0] {
        S_IDLE    = 19'b0000000000000000001,
        S_SLASH   = 19'b0000000000000000010,
        S_COMMENT = 19'b0000000000000000100,
        S_MINUS   = 19'b0000000000000001000,
        S_LESS    = 19'b0000000000000010000,
        S_GREATER = 19'b0000000000000100000,
        S_EQUAL   = 19'b0000000000001000000,
        S_BANG    = 19'b0000000000010000000,
        S_IDENT   = 19'b0000000000100000000,
        S_STRING  = 19'b0000000001000000000,
        S_ESCAPE  = 19'b0000000010000000000,
        S_ZERO    = 19'b0000000100000000000,
        S_PREFIX  = 19'b0000001000000000000,
        S_INTPART = 19'b0000010000000000000,
        S_DOT     = 19'b0000100000000000000,
        S_FRAC    = 19'b0001000000000000000,
        S_EMARK   = 19'b0010000000000000000,
        S_ESIGN   = 19'b0100000000000000000,
        S_EXP     = 19'b1000000000000000000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [PB-1:0] pos;
        logic [PB-1:0] tbeg;
        logic [62:0] acc;
        logic [1:0]  radix;
        logic        ovf;
        logic        frac;
        logic        expo;
        logic [47:0] word;
        logic [2:0]  wlen;
        logic        halted;
    } t_scan;

    typedef struct packed {
        t_scan           s;
        stt_pkg::t_group g;
    } t_work;

    t_scan r_s, n_s;
    stt_pkg::t_group n_grp;

    logic       accept;
    logic [7:0] c;
    logic [PB-1:0] pos, prv, nxt;
    logic       c_dec, c_hex, c_alpha, c_idst, c_idct, c_digok;
    logic [3:0] dig;
    logic [66:0] dig_sum;

    function automatic logic [23:0] f_p(logic [PB-1:0] p);
        return 24'(p);
    endfunction

    function automatic t_work f_emit(t_work w, logic [5:0] kind, logic [2:0] err,
                                     logic [PB-1:0] a, logic [PB-1:0] b,
                                     logic [62:0] val, logic [1:0] base, logic ex);
        t_work r;
        r = w;
        if (w.g.cnt < 2'(stt_pkg::MAX_TOK)) begin
            r.g.tok[w.g.cnt].kind       = kind;
            r.g.tok[w.g.cnt].err        = err;
            r.g.tok[w.g.cnt].span_start = f_p(a);
            r.g.tok[w.g.cnt].span_end   = f_p(b);
            r.g.tok[w.g.cnt].value      = val;
            r.g.tok[w.g.cnt].base       = base;
            r.g.tok[w.g.cnt].expo       = ex;
            r.g.cnt = w.g.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic t_work f_fail(t_work w, logic [2:0] code, logic [PB-1:0] e);
        t_work r;
        r = f_emit(w, stt_pkg::K_ERROR, code, w.s.tbeg, e, '0, stt_pkg::B_DEC, 1'b0);
        r.s.halted = 1'b1;
        r.s.mode = S_IDLE;
        return r;
    endfunction

    // halted is set via f_fail when the number ends in overflow
    function automatic t_work f_finish_num(t_work w, logic [PB-1:0] e);
        t_work r;
        r = w;
        r.s.mode = S_IDLE;
        if (w.s.frac || w.s.expo) begin
            r = f_emit(r, stt_pkg::K_FLOAT, stt_pkg::E_NONE, w.s.tbeg, e, '0,
                       stt_pkg::B_DEC, w.s.expo);
        end else if (w.s.ovf) begin
            r = f_fail(r, stt_pkg::E_OVERFLOW, e);
        end else begin
            r = f_emit(r, stt_pkg::K_INT, stt_pkg::E_NONE, w.s.tbeg, e, w.s.acc,
                       w.s.radix, 1'b0);
        end
        return r;
    endfunction

    function automatic t_work f_finish_word(t_work w, logic [PB-1:0] e);
        t_work r;
        logic [5:0] kind;
        logic hit;
        kind = stt_pkg::K_IDENT;
        hit = 1'b0;
        for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
            if (!hit && w.s.wlen == stt_pkg::KW_LEN[k]
                    && w.s.word == stt_pkg::KW_TEXT[k]) begin
                hit = 1'b1;
                kind = stt_pkg::K_KW_BASE + 6'(k);
            end
        end
        r = f_emit(w, kind, stt_pkg::E_NONE, w.s.tbeg, e, '0, stt_pkg::B_DEC, 1'b0);
        r.s.mode = S_IDLE;
        return r;
    endfunction

    function automatic t_scan f_word_add(t_scan s, logic [7:0] ch);
        t_scan r;
        r = s;
        if (s.wlen < 3'd6) begin
            r.word = {s.word[39:0], ch};
            r.wlen = s.wlen + 3'd1;
        end else begin
            r.wlen = 3'd7;
        end
        return r;
    endfunction

    assign accept = i_src.valid && i_src.ready;
    assign i_src.ready = !i_full;
    assign c = i_src.text_byte;
    assign pos = r_s.pos;
    assign prv = r_s.pos - PB'(1);
    assign nxt = r_s.pos + PB'(1);

    assign c_dec   = c >= "0" && c <= "9";
    assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign c_hex   = c_dec || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    assign c_idst  = c_alpha || c == "$" || c == "_";
    assign c_idct  = c_idst || c_dec;
    assign dig     = c_dec ? 4'(c - 8'h30) : 4'((c | 8'h20) - 8'h57);

    always_comb begin
        unique case (r_s.radix)
            stt_pkg::B_HEX: c_digok = c_hex;
            stt_pkg::B_BIN: c_digok = c == "0" || c == "1";
            default:        c_digok = c_dec;
        endcase
    end

    // acc*radix+dig past the 63-bit limit is an overflow
    always_comb begin
        unique case (r_s.radix)
            stt_pkg::B_HEX: dig_sum = {r_s.acc, 4'b0} + 67'(dig);
            stt_pkg::B_BIN: dig_sum = 67'({r_s.acc, 1'b0}) + 67'(dig);
            default: dig_sum = 67'({r_s.acc, 3'b0}) + 67'({r_s.acc, 1'b0}) + 67'(dig);
        endcase
    end

    always_comb begin
        t_work w;
        logic again;
        w.s = r_s;
        w.g = '0;
        again = !r_s.halted;
        for (int p = 0; p < 4; p++) begin
            if (again && !w.s.halted) begin
                again = 1'b0;
                unique case (w.s.mode)
                    S_IDLE: begin
                        w.s.tbeg = pos;
                        priority if (c == " " || c == 8'h09 || c == 8'h0a) begin
                        end else if (c == 8'h00) begin
                            w = f_emit(w, stt_pkg::K_END, stt_pkg::E_NONE, pos, pos, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "+") begin
                            w = f_emit(w, stt_pkg::K_PLUS, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "*") begin
                            w = f_emit(w, stt_pkg::K_STAR, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "%") begin
                            w = f_emit(w, stt_pkg::K_PERCENT, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "(") begin
                            w = f_emit(w, stt_pkg::K_LPAREN, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == ")") begin
                            w = f_emit(w, stt_pkg::K_RPAREN, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "{") begin
                            w = f_emit(w, stt_pkg::K_LBRACE, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "}") begin
                            w = f_emit(w, stt_pkg::K_RBRACE, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "[") begin
                            w = f_emit(w, stt_pkg::K_LBRACK, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "]") begin
                            w = f_emit(w, stt_pkg::K_RBRACK, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == ";") begin
                            w = f_emit(w, stt_pkg::K_SEMI, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == ":") begin
                            w = f_emit(w, stt_pkg::K_COLON, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == ",") begin
                            w = f_emit(w, stt_pkg::K_COMMA, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == ".") begin
                            w = f_emit(w, stt_pkg::K_DOT, stt_pkg::E_NONE, pos, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else if (c == "-") begin
                            w.s.mode = S_MINUS;
                        end else if (c == "/") begin
                            w.s.mode = S_SLASH;
                        end else if (c == "<") begin
                            w.s.mode = S_LESS;
                        end else if (c == ">") begin
                            w.s.mode = S_GREATER;
                        end else if (c == "=") begin
                            w.s.mode = S_EQUAL;
                        end else if (c == "!") begin
                            w.s.mode = S_BANG;
                        end else if (c == 8'h22) begin
                            w.s.mode = S_STRING;
                        end else if (c_dec) begin
                            w.s.acc   = '0;
                            w.s.radix = stt_pkg::B_DEC;
                            w.s.ovf   = 1'b0;
                            w.s.frac  = 1'b0;
                            w.s.expo  = 1'b0;
                            if (c == "0") begin
                                w.s.mode = S_ZERO;
                            end else begin
                                w.s.acc  = 63'(dig);
                                w.s.mode = S_INTPART;
                            end
                        end else if (c_idst) begin
                            w.s.word = '0;
                            w.s.wlen = '0;
                            w.s = f_word_add(w.s, c);
                            w.s.mode = S_IDENT;
                        end else begin
                            w = f_fail(w, stt_pkg::E_BAD_CHAR, pos);
                        end
                    end
                    S_SLASH: begin
                        if (c == "/") begin
                            w.s.mode = S_COMMENT;
                        end else begin
                            w = f_emit(w, stt_pkg::K_SLASH, stt_pkg::E_NONE, w.s.tbeg, pos, '0,
                                       stt_pkg::B_DEC, 1'b0);
                            w.s.mode = S_IDLE;
                            again = 1'b1;
                        end
                    end
                    S_COMMENT: begin
                        if (c == 8'h0a) begin
                            w.s.mode = S_IDLE;
                        end else if (c == 8'h00) begin
                            w.s.mode = S_IDLE;
                            again = 1'b1;
                        end
                    end
                    S_MINUS: begin
                        w.s.mode = S_IDLE;
                        if (c == "-") begin
                            w = f_emit(w, stt_pkg::K_DEC, stt_pkg::E_NONE, w.s.tbeg, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else begin
                            w = f_emit(w, stt_pkg::K_MINUS, stt_pkg::E_NONE, w.s.tbeg, pos, '0,
                                       stt_pkg::B_DEC, 1'b0);
                            again = 1'b1;
                        end
                    end
                    S_LESS, S_GREATER: begin
                        logic lt;
                        lt = w.s.mode == S_LESS;
                        w.s.mode = S_IDLE;
                        if (c == (lt ? "<" : ">")) begin
                            w = f_emit(w, lt ? stt_pkg::K_SHL : stt_pkg::K_SHR, stt_pkg::E_NONE,
                                       w.s.tbeg, nxt, '0, stt_pkg::B_DEC, 1'b0);
                        end else if (c == "=") begin
                            w = f_emit(w, lt ? stt_pkg::K_LE : stt_pkg::K_GE, stt_pkg::E_NONE,
                                       w.s.tbeg, nxt, '0, stt_pkg::B_DEC, 1'b0);
                        end else begin
                            w = f_emit(w, lt ? stt_pkg::K_LT : stt_pkg::K_GT, stt_pkg::E_NONE,
                                       w.s.tbeg, pos, '0, stt_pkg::B_DEC, 1'b0);
                            again = 1'b1;
                        end
                    end
                    S_EQUAL: begin
                        w.s.mode = S_IDLE;
                        if (c == "=") begin
                            w = f_emit(w, stt_pkg::K_EQ, stt_pkg::E_NONE, w.s.tbeg, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else begin
                            w = f_emit(w, stt_pkg::K_ASSIGN, stt_pkg::E_NONE, w.s.tbeg, pos, '0,
                                       stt_pkg::B_DEC, 1'b0);
                            again = 1'b1;
                        end
                    end
                    S_BANG: begin
                        w.s.mode = S_IDLE;
                        if (c == "=") begin
                            w = f_emit(w, stt_pkg::K_NE, stt_pkg::E_NONE, w.s.tbeg, nxt, '0,
                                       stt_pkg::B_DEC, 1'b0);
                        end else begin
                            w = f_fail(w, stt_pkg::E_BAD_CHAR, pos);
                        end
                    end
                    S_IDENT: begin
                        if (c_idct) begin
                            w.s = f_word_add(w.s, c);
                        end else begin
                            w = f_finish_word(w, pos);
                            again = 1'b1;
                        end
                    end
                    S_STRING: begin
                        if (c == 8'h22) begin
                            w = f_emit(w, stt_pkg::K_STRING, stt_pkg::E_NONE, w.s.tbeg, nxt,
                                       '0, stt_pkg::B_DEC, 1'b0);
                            w.s.mode = S_IDLE;
                        end else if (c == 8'h00) begin
                            w = f_fail(w, stt_pkg::E_UNCLOSED, pos);
                        end else if (c == 8'h5c) begin
                            w.s.mode = S_ESCAPE;
                        end
                    end
                    S_ESCAPE: begin
                        if (c == "n" || c == "r" || c == "t" || c == 8'h5c || c == 8'h22
                                || c == "0") begin
                            w.s.mode = S_STRING;
                        end else begin
                            w = f_fail(w, stt_pkg::E_BAD_ESC, pos);
                        end
                    end
                    S_ZERO: begin
                        if (c == "x" || c == "X") begin
                            w.s.radix = stt_pkg::B_HEX;
                            w.s.mode = S_PREFIX;
                        end else if (c == "b" || c == "B") begin
                            w.s.radix = stt_pkg::B_BIN;
                            w.s.mode = S_PREFIX;
                        end else begin
                            w.s.mode = S_INTPART;
                            again = 1'b1;
                        end
                    end
                    S_PREFIX, S_INTPART: begin
                        // radix is settled before this byte, so c_digok and dig_sum apply
                        if (c_digok || (w.s.mode == S_INTPART && c == "_")) begin
                            if (c != "_" && !w.s.ovf) begin
                                if (dig_sum[66:63] != 4'd0) w.s.ovf = 1'b1;
                                else w.s.acc = dig_sum[62:0];
                            end
                            w.s.mode = S_INTPART;
                        end else if (w.s.mode == S_PREFIX) begin
                            w = f_fail(w, stt_pkg::E_NUMBER, pos);
                        end else if (w.s.radix == stt_pkg::B_DEC && c == ".") begin
                            w.s.mode = S_DOT;
                        end else if (w.s.radix == stt_pkg::B_DEC && (c == "e" || c == "E")) begin
                            w.s.word = 48'(c);
                            w.s.mode = S_EMARK;
                        end else begin
                            w = f_finish_num(w, pos);
                            again = 1'b1;
                        end
                    end
                    S_DOT: begin
                        if (c_dec) begin
                            w.s.frac = 1'b1;
                            w.s.mode = S_FRAC;
                        end else begin
                            w = f_finish_num(w, prv);
                            if (!w.s.halted) begin
                                w = f_emit(w, stt_pkg::K_DOT, stt_pkg::E_NONE, prv, pos, '0,
                                           stt_pkg::B_DEC, 1'b0);
                                again = 1'b1;
                            end
                        end
                    end
                    S_FRAC: begin
                        if (c_dec || c == "_") begin
                        end else if (c == "e" || c == "E") begin
                            w.s.word = 48'(c);
                            w.s.mode = S_EMARK;
                        end else begin
                            w = f_finish_num(w, pos);
                            again = 1'b1;
                        end
                    end
                    S_EMARK: begin
                        if (c_dec) begin
                            w.s.expo = 1'b1;
                            w.s.mode = S_EXP;
                        end else if (c == "+" || c == "-") begin
                            w.s.expo = 1'b1;
                            w.s.mode = S_ESIGN;
                        end else begin
                            w = f_finish_num(w, prv);
                            if (!w.s.halted) begin
                                // the e starts an identifier
                                w.s.tbeg = prv;
                                w.s.word = {40'd0, w.s.word[7:0]};
                                w.s.wlen = 3'd1;
                                w.s.mode = S_IDENT;
                                again = 1'b1;
                            end
                        end
                    end
                    S_ESIGN: begin
                        if (c_dec) w.s.mode = S_EXP;
                        else w = f_fail(w, stt_pkg::E_NUMBER, pos);
                    end
                    S_EXP: begin
                        if (!(c_dec || c == "_")) begin
                            w = f_finish_num(w, pos);
                            again = 1'b1;
                        end
                    end
                    default: begin
                        w.s.mode = S_IDLE;
                        again = 1'b1;
                    end
                endcase
            end
        end
        n_s = w.s;
        n_grp = w.g;
        if (c == 8'h00) begin
            n_s = '0;
            n_s.mode = S_IDLE;
        end else begin
            n_s.pos = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
            r_s.mode <= S_IDLE;
        end else if (accept) begin
            r_s <= n_s;
        end
    end

    assign o_push = accept && n_grp.cnt != 2'd0;
    assign o_grp  = n_grp;

    `STT_ASSERT(a_halt_idle, i_clk, i_rst_n, !r_s.halted || r_s.mode == S_IDLE, "halted outside idle")
    `STT_NEVER(a_push_full, i_clk, i_rst_n, o_push && i_full, "push into full queue")
    `STT_ASSERT(a_mode_hot, i_clk, i_rst_n, $onehot(r_s.mode), "scan mode not one-hot")

endmodule

// ===== hdl/stt_queue.sv =====
`include "assert_macros.svh"

module stt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stt_pkg::t_group i_grp,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output stt_pkg::t_group o_head
);

    stt_pkg::t_group r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop     = i_pop && r_cnt != 3'd0;
    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push && !o_full) - 3'(pop);
        end
    end

    `STT_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'd4, "queue count out of range")
    `STT_ASSERT(a_ptr_match, i_clk, i_rst_n, (r_cnt == 3'd0 || r_cnt == 3'd4) == (r_wp == r_rp), "queue pointers disagree with count")

endmodule

// ===== hdl/stt_back.sv =====
`include "assert_macros.svh"

module stt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  stt_pkg::t_group i_head,
    output logic            o_pop,
    stt_token_if.source     o_tok
);

    logic          r_valid;
    logic [1:0]    r_idx;
    stt_pkg::t_token r_tok;
    logic          r_last;
    logic          load, last;

    assign load  = (!r_valid || o_tok.ready) && !i_empty;
    assign last  = r_idx == i_head.cnt - 2'd1;
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.tok[r_idx];
            r_last <= last;
        end
    end

    assign o_tok.valid        = r_valid;
    assign o_tok.token_kind   = r_tok.kind;
    assign o_tok.error_code   = r_tok.err;
    assign o_tok.span_start   = r_tok.span_start;
    assign o_tok.span_end     = r_tok.span_end;
    assign o_tok.int_value    = r_tok.value;
    assign o_tok.int_base     = r_tok.base;
    assign o_tok.has_exponent = r_tok.expo;
    assign o_tok.last_of_run  = r_last;

    `STT_ASSERT(a_idx_bound, i_clk, i_rst_n, i_empty || r_idx < i_head.cnt, "token index past group")
    `STT_ASSERT(a_idx_reset, i_clk, i_rst_n, !$past(o_pop) || r_idx == 2'd0, "index not rewound after group")

endmodule

// ===== hdl/source_text_tokenizer_unit.sv =====
// Streaming lexer: takes one source byte per cycle on i_src and delivers tokens
// on o_tok, one per cycle when the sink is ready. A byte that completes k tokens
// (at most three) yields k output tokens in turn; the scanner runs ahead through
// a four-entry group queue and only stalls its input when that queue is full.
// A zero byte ends the text and restarts positions at zero. After an error token
// all bytes up to and including the zero byte are consumed without output.
module source_text_tokenizer_unit #(
    parameter int unsigned POSITION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stt_byte_if.sink    i_src,
    stt_token_if.source o_tok
);

    logic            push, pop, full, empty;
    stt_pkg::t_group grp, head;

    stt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_full  (full),
        .o_push  (push),
        .o_grp   (grp)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

endmodule
